/* rtl/ldsk_pkg.sv */
// Shared types and constants for the LOOK disk scheduler.
`timescale 1ns / 1ps

package ldsk_pkg;

	localparam int TRACK_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP    = 1'd1;

	// First sweep direction
	localparam logic UP   = 1'b1;
	localparam logic DOWN = 1'b0;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               last;
	} req_t;

	typedef struct packed {
		logic [TRACK_W-1:0] track;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [TRACK_W-1:0] start_track;
		logic               sweep_up;
	} cfg_t;

endpackage

/* rtl/ldsk_fifo.sv */
// Small register FIFO used to decouple the scheduler's back end from its request and result sides.
`timescale 1ns / 1ps

module ldsk_fifo #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/ldsk_back.sv */
// Sorted request row and LOOK emission sequencer.
`timescale 1ns / 1ps

module ldsk_back #(
	parameter int MAX_REQUESTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_empty,
	output logic          req_pop,
	input  ldsk_pkg::req_t req,
	input  ldsk_pkg::cfg_t cfg,
	input  logic          res_full,
	output logic          res_push,
	output ldsk_pkg::res_t res
);

	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	localparam int          STATE_W = 3;
	localparam logic [2:0]  ST_IDLE = 3'd0;
	localparam logic [2:0]  ST_CMP  = 3'd1;
	localparam logic [2:0]  ST_HEAD = 3'd2;
	localparam logic [2:0]  ST_ASC  = 3'd3;
	localparam logic [2:0]  ST_DESC = 3'd4;

	logic [ldsk_pkg::TRACK_W-1:0] row_q [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0]      gt;
	logic [MAX_REQUESTS-1:0]      lt;
	logic [MAX_REQUESTS-1:0]      wr_here;
	logic [MAX_REQUESTS-1:0]      lt_q;
	logic [MAX_REQUESTS-1:0]      lt_nx;
	logic [STATE_W-1:0]           state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             ptr_q;
	logic [CNT_W-1:0]             ptr_dec;
	logic [CNT_W-1:0]             below_q;
	logic [CNT_W-1:0]             below_c;
	logic [CNT_W-1:0]             remaining_q;
	logic [IDX_W-1:0]             rd_idx;
	logic                         ins_en;

	assign req_pop = (state_q == ST_IDLE) && !req_empty;
	assign ins_en  = req_pop && (count_q < CNT_W'(MAX_REQUESTS));
	assign ptr_dec = ptr_q - CNT_W'(1);
	assign rd_idx  = (state_q == ST_ASC) ? ptr_q[IDX_W-1:0] : ptr_dec[IDX_W-1:0];
	assign lt_nx   = lt_q >> 1;

	// Compare every stored entry against the new request and the start track
	always_comb begin
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			gt[i]      = (CNT_W'(i) < count_q) && (row_q[i] > req.track);
			lt[i]      = (CNT_W'(i) < count_q) && (row_q[i] < cfg.start_track);
			wr_here[i] = gt[i] || (CNT_W'(i) == count_q);
		end
	end

	// Entries below the start track form a thermometer; its edge gives the split
	always_comb begin
		below_c = '0;
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			if (lt_q[i] && !lt_nx[i]) begin
				below_c = below_c | CNT_W'(i + 1);
			end
		end
	end

	// Parallel insertion: larger entries shift up one place
	for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_row
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (ins_en && wr_here[g]) begin
					row_q[g] <= req.track;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (ins_en && wr_here[g]) begin
					row_q[g] <= gt[g-1] ? row_q[g-1] : req.track;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			lt_q <= lt;
		end
	end

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			ST_HEAD: begin
				res_push  = !res_full;
				res.track = cfg.start_track;
				res.last  = (count_q == '0);
			end
			ST_ASC, ST_DESC: begin
				res_push  = !res_full;
				res.track = row_q[rd_idx];
				res.last  = (remaining_q == CNT_W'(1));
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			below_q     <= '0;
			remaining_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ins_en) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (req_pop && req.last) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (!res_full) begin
						remaining_q <= count_q;
						below_q     <= below_c;
						ptr_q       <= below_c;
						if (count_q == '0) begin
							state_q <= ST_IDLE;
						end else if (cfg.sweep_up == ldsk_pkg::UP) begin
							state_q <= (below_c < count_q) ? ST_ASC : ST_DESC;
						end else begin
							state_q <= (below_c != '0) ? ST_DESC : ST_ASC;
						end
					end
				end
				ST_ASC: begin
					if (!res_full) begin
						remaining_q <= remaining_q - CNT_W'(1);
						if (remaining_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
							count_q <= '0;
						end else if (ptr_q + CNT_W'(1) == count_q) begin
							state_q <= ST_DESC;
							ptr_q   <= below_q;
						end else begin
							ptr_q <= ptr_q + CNT_W'(1);
						end
					end
				end
				ST_DESC: begin
					if (!res_full) begin
						remaining_q <= remaining_q - CNT_W'(1);
						if (remaining_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
							count_q <= '0;
						end else if (ptr_q == CNT_W'(1)) begin
							state_q <= ST_ASC;
							ptr_q   <= below_q;
						end else begin
							ptr_q <= ptr_dec;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count beyond capacity");

	a_push_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (state_q == ST_HEAD || state_q == ST_ASC || state_q == ST_DESC))
		else $error("result pushed outside emission");

	a_asc_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ASC) |-> (ptr_q < count_q && remaining_q != '0))
		else $error("ascending pointer out of range");

	a_desc_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DESC) |-> (ptr_q != '0 && ptr_q <= below_q))
		else $error("descending pointer out of range");

	a_no_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_pop)
		else $error("request taken during emission");

endmodule

/* rtl/look_disk_scheduler.sv */
// Top level of the LOOK disk scheduler.
`timescale 1ns / 1ps

// LOOK disk scheduler. Requests (track, last mark) are pushed into a two-entry
// input queue; while idle, the back end takes one request per cycle from it and
// inserts it, in the cycle it is taken, into a sorted register row of
// MAX_REQUESTS entries. Requests arriving with the row full are dropped, but
// their last mark still ends the batch. On the request marked last the back
// end moves to a compare state that compares the row against start_track,
// then emits the start track and every stored track in LOOK order at one
// result per cycle into a two-entry result queue, unless that queue is full:
// sweep_up = 1 serves tracks at or above the start in ascending order, then
// those below in descending order; sweep_up = 0 reverses both runs. A batch
// of n stored requests thus yields n + 1 results; while emitting, the back
// end takes no request, and the input queue fills and raises full. The last
// result of each batch carries last_result.
// Write configuration only while the block is idle; start_track and sweep_up
// are read in the compare and head states after the batch's last request.
module look_disk_scheduler #(
	parameter int MAX_REQUESTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request side
	input  logic                            push,
	output logic                            full,
	input  logic [ldsk_pkg::TRACK_W-1:0]    request_track,
	input  logic                            last_request,
	// result side
	output logic                            empty,
	input  logic                            pop,
	output logic [ldsk_pkg::TRACK_W-1:0]    service_track,
	output logic                            last_result,
	// configuration
	input  logic                            cfg_write,
	input  logic [ldsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldsk_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int REQ_W = $bits(ldsk_pkg::req_t);
	localparam int RES_W = $bits(ldsk_pkg::res_t);

	ldsk_pkg::cfg_t cfg_q;
	ldsk_pkg::req_t req_in;
	ldsk_pkg::req_t req_head;
	ldsk_pkg::res_t res_back;
	ldsk_pkg::res_t res_head;
	logic           req_empty;
	logic           req_pop;
	logic           res_full;
	logic           res_push;

	// Configuration registers: write-only, taken at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_track <= '0;
			cfg_q.sweep_up    <= ldsk_pkg::UP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ldsk_pkg::CFG_START_TRACK: cfg_q.start_track <= cfg_data;
				ldsk_pkg::CFG_SWEEP_UP:    cfg_q.sweep_up    <= cfg_data[0];
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	assign req_in.track = request_track;
	assign req_in.last  = last_request;

	// Front: hold incoming requests until the back end is free
	ldsk_fifo #(
		.WIDTH (REQ_W),
		.DEPTH (2)
	) u_req_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (req_in),
		.pop    (req_pop),
		.empty  (req_empty),
		.rdata  (req_head)
	);

	// Back: sort the batch and sequence the service order
	ldsk_back #(
		.MAX_REQUESTS (MAX_REQUESTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_empty (req_empty),
		.req_pop   (req_pop),
		.req       (req_head),
		.cfg       (cfg_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_back)
	);

	// Result queue: advance the sequencer while the consumer stalls
	ldsk_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_back),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_head)
	);

	assign service_track = res_head.track;
	assign last_result   = res_head.last;

endmodule

/* tb/look_disk_scheduler_checker.sv */
// Checker for the LOOK disk scheduler: predicts the service order and compares results.
`timescale 1ns / 1ps

module look_disk_scheduler_checker #(
	parameter int MAX_REQUESTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [ldsk_pkg::TRACK_W-1:0]    request_track,
	input  logic                            last_request,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [ldsk_pkg::TRACK_W-1:0]    service_track,
	input  logic                            last_result,
	input  logic                            cfg_write,
	input  logic [ldsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldsk_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              outstanding
);

	logic [ldsk_pkg::TRACK_W-1:0] track_row [MAX_REQUESTS];
	int unsigned                  stored;
	logic [ldsk_pkg::TRACK_W-1:0] head_start;
	logic                         head_dir;
	ldsk_pkg::res_t               service_q [$];

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		errors++;
	endtask

	// Insert the track into the sorted row; on the last request queue the LOOK order.
	task automatic take_request(input logic [ldsk_pkg::TRACK_W-1:0] trk, input logic lst);
		int unsigned p;
		int unsigned below;
		int unsigned i;
		if (stored < MAX_REQUESTS) begin
			p = stored;
			while (p > 0 && track_row[p-1] > trk) begin
				track_row[p] = track_row[p-1];
				p--;
			end
			track_row[p] = trk;
			stored++;
		end
		if (!lst)
			return;
		below = 0;
		for (i = 0; i < stored; i++)
			if (track_row[i] < head_start)
				below++;
		service_q.push_back({head_start, 1'b0});
		if (head_dir == ldsk_pkg::UP) begin
			for (i = below; i < stored; i++)
				service_q.push_back({track_row[i], 1'b0});
			for (i = below; i > 0; i--)
				service_q.push_back({track_row[i-1], 1'b0});
		end else begin
			for (i = below; i > 0; i--)
				service_q.push_back({track_row[i-1], 1'b0});
			for (i = below; i < stored; i++)
				service_q.push_back({track_row[i], 1'b0});
		end
		service_q[service_q.size()-1].last = 1'b1;
		stored = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ldsk_pkg::res_t want;
		if (!arst_n) begin
			stored      = 0;
			head_start  = '0;
			head_dir    = ldsk_pkg::UP;
			service_q.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty) begin
				if (service_q.size() == 0) begin
					report_mismatch($sformatf("result %h/%b with none expected",
						service_track, last_result));
				end else begin
					want = service_q.pop_front();
					if (service_track !== want.track)
						report_mismatch($sformatf("service_track %h, expected %h",
							service_track, want.track));
					if (last_result !== want.last)
						report_mismatch($sformatf("last_result %b, expected %b",
							last_result, want.last));
				end
			end
			if (push && !full)
				take_request(request_track, last_request);
			if (cfg_write) begin
				case (cfg_index)
					ldsk_pkg::CFG_START_TRACK: head_start = cfg_data[ldsk_pkg::TRACK_W-1:0];
					ldsk_pkg::CFG_SWEEP_UP:    head_dir   = cfg_data[0];
					default:                   ;
				endcase
			end
			outstanding = service_q.size();
		end
	end

endmodule

/* tb/look_disk_scheduler_tb.sv */
// Testbench top for the LOOK disk scheduler: stimulus, idling and verdict.
`timescale 1ns / 1ps

module look_disk_scheduler_tb;

	localparam int MAX_REQUESTS = 32;
	localparam int ITEMS_PER_SETTING = 21;
	localparam int TRACK_W    = ldsk_pkg::TRACK_W;
	localparam int CFG_IDX_W  = ldsk_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = ldsk_pkg::CFG_DATA_W;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [TRACK_W-1:0]    request_track;
	logic                  last_request;
	logic                  empty;
	logic                  pop;
	logic [TRACK_W-1:0]    service_track;
	logic                  last_result;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int outstanding;

	// Idle percentages for each side; changed per phase.
	int send_idle_pct = 0;
	int pop_stall_pct = 0;

	// Mirror of the start track, used to aim requests near the head.
	logic [TRACK_W-1:0] cur_start;
	int                 setting_items;

	look_disk_scheduler #(.MAX_REQUESTS(MAX_REQUESTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.request_track (request_track),
		.last_request  (last_request),
		.empty         (empty),
		.pop           (pop),
		.service_track (service_track),
		.last_result   (last_result),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	look_disk_scheduler_checker #(.MAX_REQUESTS(MAX_REQUESTS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.request_track (request_track),
		.last_request  (last_request),
		.empty         (empty),
		.pop           (pop),
		.service_track (service_track),
		.last_result   (last_result),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	always #6 clk = ~clk;

	// Result side: stall pop at random at the phase's rate; zero means always ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Offer one request, idling first at random, and hold it until it is taken.
	task automatic send_request(input logic [TRACK_W-1:0] trk, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		request_track <= trk;
		last_request  <= lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		setting_items++;
	endtask

	// Wait for every expected result, then let the back end settle.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write both registers back to back; upper data bits of the direction are junk.
	task automatic set_config(input logic [TRACK_W-1:0] st, input logic dir);
		cfg_write <= 1'b1;
		cfg_index <= ldsk_pkg::CFG_START_TRACK;
		cfg_data  <= st;
		@(posedge clk);
		cfg_index <= ldsk_pkg::CFG_SWEEP_UP;
		cfg_data  <= CFG_DATA_W'(($urandom() << 1) | dir);
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_start = st;
	endtask

	// Pick a track: full range, near the head, the extremes, or a small pool for duplicates.
	function automatic logic [TRACK_W-1:0] pick_track();
		case ($urandom_range(3))
			0:       return TRACK_W'($urandom());
			1:       return cur_start + TRACK_W'($urandom_range(8)) - TRACK_W'(4);
			2:       return $urandom_range(1) ? '1 : '0;
			default: return TRACK_W'($urandom_range(3) * 16'h3FFF);
		endcase
	endfunction

	task automatic send_batch(input int unsigned len);
		int unsigned k;
		for (k = 0; k < len; k++)
			send_request(pick_track(), k == len - 1);
	endtask

	// One register setting: mostly short batches, now and then one past the row's capacity.
	task automatic run_setting(input logic [TRACK_W-1:0] st, input logic dir,
			input bit force_overflow);
		drain();
		set_config(st, dir);
		setting_items = 0;
		if (force_overflow)
			send_batch(MAX_REQUESTS + 4);
		while (setting_items < ITEMS_PER_SETTING) begin
			if ($urandom_range(99) < 5)
				send_batch($urandom_range(MAX_REQUESTS + 8, MAX_REQUESTS + 1));
			else
				send_batch($urandom_range(10, 1));
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input bit force_overflow);
		send_idle_pct = idle;
		pop_stall_pct = stall;
		run_setting('0, 1'($urandom_range(1)), force_overflow);
		run_setting('1, 1'($urandom_range(1)), 1'b0);
		run_setting(TRACK_W'($urandom()), 1'($urandom_range(1)), 1'b0);
	endtask

	initial begin
		arst_n        <= 1'b0;
		push          <= 1'b0;
		request_track <= '0;
		last_request  <= 1'b0;
		cfg_write     <= 1'b0;
		cfg_index     <= ldsk_pkg::CFG_START_TRACK;
		cfg_data      <= '0;
		cur_start     = '0;
		setting_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: head mid-disk, sweep up; duplicates, extremes, a request on the head.
		set_config(16'h8000, ldsk_pkg::UP);
		send_request(16'h8000, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h8000, 1'b0);
		send_request(16'h7FFF, 1'b1);
		drain();

		// Same head, sweep down.
		set_config(16'h8000, ldsk_pkg::DOWN);
		send_request(16'h1234, 1'b0);
		send_request(16'h8000, 1'b0);
		send_request(16'h0001, 1'b0);
		send_request(16'hFFFE, 1'b1);
		drain();

		// Head at track zero sweeping down: nothing lies below.
		set_config(16'h0000, ldsk_pkg::DOWN);
		send_request(16'h0000, 1'b0);
		send_request(16'hFFFF, 1'b1);
		drain();

		// Head at the top sweeping up: all but the top track lie below.
		set_config(16'hFFFF, ldsk_pkg::UP);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h0000, 1'b0);
		send_request(16'h5555, 1'b1);
		send_request(16'hAAAA, 1'b1);
		send_request(16'h0000, 1'b1);

		// Random: no idling, sender idle, receiver stalling, then both.
		run_phase(0, 0, 1'b1);
		run_phase(63, 0, 1'b0);
		run_phase(0, 63, 1'b0);
		run_phase(26, 26, 1'b1);
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
